// ----- rtl/etseg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter package
// Shared widths, register indexes, codes and the front-to-back command type.
// ----------------------------------------------------------------------------
package etseg_pkg;

	localparam int TIME_BITS   = 63;
	localparam int CFG_BITS    = 48;
	localparam int COORD_BITS  = 11;
	localparam int BP_BITS     = 2 * COORD_BITS + 1;
	localparam int BP_VALID    = 2 * COORD_BITS;
	localparam int CFG_IDX_BITS = 3;

	localparam int BAD_PIXEL_SLOTS_DEF = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_BITS-1:0] SEG_LEN_RESET = 48'd10000000;

	localparam logic [CFG_IDX_BITS-1:0] CFG_START_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_LENGTH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BAD_PIXEL_A   = 3'd3;

	localparam logic REQ_EVENT = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	localparam logic RK_RECORD = 1'b0;
	localparam logic RK_CLOSE  = 1'b1;

	typedef struct packed {
		logic [CFG_BITS-1:0] start_offset;
		logic [CFG_BITS-1:0] window_length;
		logic [CFG_BITS-1:0] segment_length;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		OP_INIT,
		OP_EVENT,
		OP_CLOSE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic                  init;
		logic [TIME_BITS-1:0]  base;
		logic [TIME_BITS-1:0]  time_ns;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  pol;
	} cmd_t;

	typedef struct packed {
		logic                  kind;
		logic [TIME_BITS-1:0]  seg_start;
		logic [TIME_BITS-1:0]  time_ns;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  pol;
		logic                  last;
	} result_t;

endpackage

// ----- rtl/etseg_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter configuration registers
// Write-only register file for window, segment and bad pixel settings.
// ----------------------------------------------------------------------------
module etseg_cfg #(
	parameter int BAD_PIXEL_SLOTS = etseg_pkg::BAD_PIXEL_SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [etseg_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [etseg_pkg::CFG_BITS-1:0]         cfg_data,
	output etseg_pkg::cfg_regs_t                   regs,
	output logic [etseg_pkg::BP_BITS-1:0]          bad_pixel [BAD_PIXEL_SLOTS]
);

	etseg_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_offset   <= '0;
			regs_q.window_length  <= '0;
			regs_q.segment_length <= etseg_pkg::SEG_LEN_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				etseg_pkg::CFG_START_OFFSET:   regs_q.start_offset   <= cfg_data;
				etseg_pkg::CFG_WINDOW_LENGTH:  regs_q.window_length  <= cfg_data;
				etseg_pkg::CFG_SEGMENT_LENGTH: regs_q.segment_length <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < BAD_PIXEL_SLOTS; i++) begin : g_slot
		logic [etseg_pkg::BP_BITS-1:0] entry_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				entry_q <= '0;
			end else if (cfg_write &&
				cfg_index == etseg_pkg::CFG_IDX_BITS'(etseg_pkg::CFG_BAD_PIXEL_A + i)) begin
				entry_q <= cfg_data[etseg_pkg::BP_BITS-1:0];
			end
		end

		assign bad_pixel[i] = entry_q;
	end

	assign regs = regs_q;

endmodule

// ----- rtl/etseg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter front end
// Takes items, fixes the window on the first event and classifies each item.
// ----------------------------------------------------------------------------
module etseg_front #(
	parameter int BAD_PIXEL_SLOTS = etseg_pkg::BAD_PIXEL_SLOTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic [etseg_pkg::TIME_BITS-1:0]        event_time_ns,
	input  logic [etseg_pkg::COORD_BITS-1:0]       pixel_col,
	input  logic [etseg_pkg::COORD_BITS-1:0]       pixel_row,
	input  logic                                   polarity,
	input  etseg_pkg::cfg_regs_t                   regs,
	input  logic [etseg_pkg::BP_BITS-1:0]          bad_pixel [BAD_PIXEL_SLOTS],
	output logic                                   push,
	output etseg_pkg::cmd_t                        push_cmd,
	input  logic                                   q_full
);

	localparam int TB = etseg_pkg::TIME_BITS;
	localparam int CB = etseg_pkg::COORD_BITS;

	typedef enum logic [1:0] {
		F_IDLE,
		F_BASE,
		F_FIN,
		F_CLASS
	} fstate_t;

	typedef struct packed {
		logic          req;
		logic [TB-1:0] time_ns;
		logic [CB-1:0] col;
		logic [CB-1:0] row;
		logic          pol;
	} item_t;

	fstate_t       state_q;
	item_t         item_q;
	logic          base_seen_q;
	logic          begun_q;
	logic          finished_q;
	logic [TB-1:0] win_begin_q;
	logic [TB-1:0] win_finish_q;

	logic          bad;
	logic          want_push;
	logic          set_fin;
	logic          set_begun;
	logic          accept;

	function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
		input logic [etseg_pkg::CFG_BITS-1:0] b);
		logic [TB:0] s;
		s = {1'b0, a} + (TB+1)'(b);
		return s[TB] ? {TB{1'b1}} : s[TB-1:0];
	endfunction

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < BAD_PIXEL_SLOTS; i++) begin
			if (bad_pixel[i][etseg_pkg::BP_VALID] &&
				bad_pixel[i][2*CB-1:CB] == item_q.col &&
				bad_pixel[i][CB-1:0] == item_q.row) begin
				bad = 1'b1;
			end
		end
	end

	always_comb begin
		push_cmd.op      = etseg_pkg::OP_EVENT;
		push_cmd.init    = !begun_q;
		push_cmd.base    = win_begin_q;
		push_cmd.time_ns = item_q.time_ns;
		push_cmd.col     = item_q.col;
		push_cmd.row     = item_q.row;
		push_cmd.pol     = item_q.pol;
		want_push = 1'b0;
		set_fin   = 1'b0;
		set_begun = 1'b0;
		if (item_q.req == etseg_pkg::REQ_FLUSH) begin
			push_cmd.op   = etseg_pkg::OP_CLOSE;
			push_cmd.init = 1'b0;
			want_push = 1'b1;
			set_fin   = 1'b1;
		end else if (item_q.time_ns < win_begin_q) begin
			want_push = 1'b0;
		end else if (regs.window_length != '0 && item_q.time_ns >= win_finish_q) begin
			push_cmd.op   = etseg_pkg::OP_CLOSE;
			push_cmd.init = 1'b0;
			want_push = 1'b1;
			set_fin   = 1'b1;
		end else begin
			set_begun = 1'b1;
			if (bad) begin
				push_cmd.op = etseg_pkg::OP_INIT;
				want_push   = !begun_q;
			end else begin
				want_push = 1'b1;
			end
		end
	end

	assign in_stall = (state_q != F_IDLE);
	assign accept   = in_valid && (state_q == F_IDLE);
	assign push     = (state_q == F_CLASS) && want_push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			item_q       <= '0;
			base_seen_q  <= 1'b0;
			begun_q      <= 1'b0;
			finished_q   <= 1'b0;
			win_begin_q  <= '0;
			win_finish_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						item_q <= '{req_type, event_time_ns, pixel_col, pixel_row, polarity};
						if (finished_q)
							state_q <= F_IDLE;
						else if (!base_seen_q && req_type == etseg_pkg::REQ_EVENT)
							state_q <= F_BASE;
						else
							state_q <= F_CLASS;
					end
				end
				F_BASE: begin
					win_begin_q <= sat_add(item_q.time_ns, regs.start_offset);
					base_seen_q <= 1'b1;
					state_q     <= F_FIN;
				end
				F_FIN: begin
					win_finish_q <= (regs.window_length != '0) ?
						sat_add(win_begin_q, regs.window_length) : '0;
					state_q <= F_CLASS;
				end
				F_CLASS: begin
					if (!want_push || !q_full) begin
						if (set_fin)
							finished_q <= 1'b1;
						if (set_begun)
							begun_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/etseg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter command queue
// Short FIFO decoupling the classifier from the segment engine.
// ----------------------------------------------------------------------------
module etseg_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  etseg_pkg::cmd_t  push_cmd,
	output logic             full,
	input  logic             pop,
	output etseg_pkg::cmd_t  pop_cmd,
	output logic             empty
);

	localparam int DEPTH = etseg_pkg::QUEUE_DEPTH;
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	etseg_pkg::cmd_t         mem_q [DEPTH];
	logic [PTR_BITS-1:0]     wr_ptr_q;
	logic [PTR_BITS-1:0]     rd_ptr_q;
	logic [CNT_BITS-1:0]     count_q;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/etseg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter segment engine
// Tracks the open segment, advances it by whole lengths and drives results.
// ----------------------------------------------------------------------------
module etseg_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [etseg_pkg::CFG_BITS-1:0]    segment_length,
	output logic                              pop,
	input  etseg_pkg::cmd_t                   pop_cmd,
	input  logic                              q_empty,
	output logic                              out_valid,
	input  logic                              out_stall,
	output etseg_pkg::result_t                result
);

	localparam int TB = etseg_pkg::TIME_BITS;
	localparam int LB = etseg_pkg::CFG_BITS;
	localparam int CNT_BITS = $clog2(TB);
	localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(TB - 1);

	typedef enum logic [2:0] {
		B_IDLE,
		B_EVAL,
		B_DIV,
		B_ADV,
		B_REC,
		B_CLOSE
	} bstate_t;

	bstate_t              state_q;
	etseg_pkg::cmd_t      cmd_q;
	logic [TB-1:0]        seg_q;
	logic                 has_ev_q;
	logic [TB-1:0]        elap_q;
	logic [LB-1:0]        rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 out_valid_q;
	etseg_pkg::result_t   result_q;

	logic [LB-1:0]        len;
	logic [TB:0]          diff;
	logic                 need_adv;
	logic [LB:0]          trial;
	logic [LB-1:0]        rem_next;
	logic                 out_free;
	logic                 emit;
	etseg_pkg::result_t   marker;
	etseg_pkg::result_t   record;

	assign len      = (segment_length == '0) ? LB'(1) : segment_length;
	assign diff     = {1'b0, cmd_q.time_ns} - {1'b0, seg_q};
	assign need_adv = !diff[TB] && (diff[TB-1:0] >= TB'(len));

	// one remainder bit per cycle
	assign trial    = {rem_q, elap_q[TB-1]};
	assign rem_next = (trial >= {1'b0, len}) ? LB'(trial - {1'b0, len}) : trial[LB-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == B_IDLE) && !q_empty;
	assign emit     = out_free && ((state_q == B_REC) ||
		(has_ev_q && (state_q == B_ADV || state_q == B_CLOSE)));

	always_comb begin
		marker           = '0;
		marker.kind      = etseg_pkg::RK_CLOSE;
		marker.seg_start = seg_q;
		marker.last      = (state_q == B_CLOSE);
		record           = '0;
		record.kind      = etseg_pkg::RK_RECORD;
		record.seg_start = seg_q;
		record.time_ns   = cmd_q.time_ns;
		record.col       = cmd_q.col;
		record.row       = cmd_q.row;
		record.pol       = cmd_q.pol;
		record.last      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cmd_q       <= '0;
			seg_q       <= '0;
			has_ev_q    <= 1'b0;
			elap_q      <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						cmd_q <= pop_cmd;
						if (pop_cmd.init)
							seg_q <= pop_cmd.base;
						case (pop_cmd.op)
							etseg_pkg::OP_EVENT: state_q <= B_EVAL;
							etseg_pkg::OP_CLOSE: state_q <= B_CLOSE;
							default:             state_q <= B_IDLE;
						endcase
					end
				end
				B_EVAL: begin
					if (need_adv) begin
						elap_q  <= diff[TB-1:0];
						rem_q   <= '0;
						cnt_q   <= DIV_LAST;
						state_q <= B_DIV;
					end else begin
						state_q <= B_REC;
					end
				end
				B_DIV: begin
					rem_q  <= rem_next;
					elap_q <= {elap_q[TB-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= B_ADV;
				end
				B_ADV: begin
					if (!has_ev_q) begin
						seg_q   <= cmd_q.time_ns - TB'(rem_q);
						state_q <= B_REC;
					end else if (out_free) begin
						result_q    <= marker;
						has_ev_q    <= 1'b0;
						seg_q       <= cmd_q.time_ns - TB'(rem_q);
						state_q     <= B_REC;
					end
				end
				B_REC: begin
					if (out_free) begin
						result_q    <= record;
						has_ev_q    <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				B_CLOSE: begin
					if (!has_ev_q) begin
						state_q <= B_IDLE;
					end else if (out_free) begin
						result_q      <= marker;
						has_ev_q      <= 1'b0;
						state_q       <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ----- rtl/event_time_segmenter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter
// Windows an event-camera stream and groups kept events into time segments.
// ----------------------------------------------------------------------------
// The front end takes one item at a time (the first event, which fixes the
// window, also passes the base and finish states) and hands kept events and
// segment closes through a two-entry queue to the segment engine. An event
// that stays in the open segment passes the engine's idle, evaluate and
// record states; one past it also goes through the bit-serial remainder unit
// and an advance step that moves the segment start and issues the close
// marker when the old segment held events. Results leave through an output
// register, so the engine works on while a result waits to be taken.
module event_time_segmenter_top #(
	parameter int BAD_PIXEL_SLOTS = etseg_pkg::BAD_PIXEL_SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [etseg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [etseg_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [etseg_pkg::TIME_BITS-1:0]      event_time_ns,
	input  logic [etseg_pkg::COORD_BITS-1:0]     pixel_col,
	input  logic [etseg_pkg::COORD_BITS-1:0]     pixel_row,
	input  logic                                 polarity,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 result_kind,
	output logic [etseg_pkg::TIME_BITS-1:0]      segment_start_ns,
	output logic [etseg_pkg::TIME_BITS-1:0]      out_time_ns,
	output logic [etseg_pkg::COORD_BITS-1:0]     out_col,
	output logic [etseg_pkg::COORD_BITS-1:0]     out_row,
	output logic                                 out_polarity,
	output logic                                 last_of_run
);

	etseg_pkg::cfg_regs_t          regs;
	logic [etseg_pkg::BP_BITS-1:0] bad_pixel [BAD_PIXEL_SLOTS];
	logic                          push;
	etseg_pkg::cmd_t               push_cmd;
	logic                          q_full;
	logic                          pop;
	etseg_pkg::cmd_t               pop_cmd;
	logic                          q_empty;
	etseg_pkg::result_t            result;

	etseg_cfg #(
		.BAD_PIXEL_SLOTS(BAD_PIXEL_SLOTS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs),
		.bad_pixel (bad_pixel)
	);

	etseg_front #(
		.BAD_PIXEL_SLOTS(BAD_PIXEL_SLOTS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.event_time_ns (event_time_ns),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.polarity      (polarity),
		.regs          (regs),
		.bad_pixel     (bad_pixel),
		.push          (push),
		.push_cmd      (push_cmd),
		.q_full        (q_full)
	);

	etseg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	etseg_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.segment_length (regs.segment_length),
		.pop            (pop),
		.pop_cmd        (pop_cmd),
		.q_empty        (q_empty),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result)
	);

	assign result_kind      = result.kind;
	assign segment_start_ns = result.seg_start;
	assign out_time_ns      = result.time_ns;
	assign out_col          = result.col;
	assign out_row          = result.row;
	assign out_polarity     = result.pol;
	assign last_of_run      = result.last;

endmodule

// ----- bench/tb_event_time_segmenter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event time segmenter testbench
// Drives one event stream through the segmenter and checks every result
// against an in-bench predictor. It opens with a short directed run over the
// window edges, the bad pixel slots and segment rollover. Random phases then
// vary the segment length, the window settings and the bad pixel slots under
// different idling patterns, with two long output stalls. The stream ends with
// a flush or an event at the window end, followed by items that must be
// ignored.
// ----------------------------------------------------------------------------
module tb_event_time_segmenter_top;

	localparam int TW = etseg_pkg::TIME_BITS;
	localparam int CW = etseg_pkg::CFG_BITS;
	localparam int XW = etseg_pkg::COORD_BITS;
	localparam int IW = etseg_pkg::CFG_IDX_BITS;
	localparam int SLOTS = etseg_pkg::BAD_PIXEL_SLOTS_DEF;
	localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
	localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};
	localparam logic [TW-1:0] WIN_OPEN = 63'h7FFF_8000_0000_0000;
	localparam logic [TW-1:0] CURSOR_CAP = 63'h7FFF_FF00_0000_0000;
	localparam logic [63:0] STRIDE_CAP = 64'h0000_0100_0000_0000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LONG_HOLD = 600;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

	typedef struct packed {
		logic          kind;
		logic [TW-1:0] ts;
		logic [XW-1:0] col;
		logic [XW-1:0] row;
		logic          pol;
	} camera_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [IW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = etseg_pkg::REQ_EVENT;
	logic [TW-1:0] event_time_ns = '0;
	logic [XW-1:0] pixel_col = '0;
	logic [XW-1:0] pixel_row = '0;
	logic polarity = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic result_kind;
	logic [TW-1:0] segment_start_ns;
	logic [TW-1:0] out_time_ns;
	logic [XW-1:0] out_col;
	logic [XW-1:0] out_row;
	logic out_polarity;
	logic last_of_run;

	event_time_segmenter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.event_time_ns(event_time_ns),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.polarity(polarity),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.segment_start_ns(segment_start_ns),
		.out_time_ns(out_time_ns),
		.out_col(out_col),
		.out_row(out_row),
		.out_polarity(out_polarity),
		.last_of_run(last_of_run)
	);

	// register copies
	logic [CW-1:0] offset_cfg = '0;
	logic [CW-1:0] window_cfg = '0;
	logic [CW-1:0] seglen_cfg = etseg_pkg::SEG_LEN_RESET;
	logic [etseg_pkg::BP_BITS-1:0] bad_pixel_cfg [SLOTS] = '{default: '0};

	// segmenter state
	logic base_fixed = 1'b0;
	logic [TW-1:0] win_open_ns = '0;
	logic [TW-1:0] win_close_ns = '0;
	logic window_entered = 1'b0;
	logic [TW-1:0] seg_start_ns = '0;
	logic seg_busy = 1'b0;
	logic stream_done = 1'b0;

	camera_item_t event_queue[$];
	camera_item_t item_on_port;
	etseg_pkg::result_t pending_results[$];
	logic [TW-1:0] time_cursor;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	logic long_hold_on = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL event_time_segmenter_top");
			$finish;
		end
	end

	function automatic logic [63:0] wide_rand();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [TW-1:0] clamp_time_sum(input logic [TW-1:0] a,
			input logic [CW-1:0] b);
		logic [63:0] sum;
		sum = 64'(a) + 64'(b);
		return (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TW-1:0];
	endfunction

	function automatic logic pixel_blocked(input logic [XW-1:0] col,
			input logic [XW-1:0] row);
		for (int i = 0; i < SLOTS; i++) begin
			if (bad_pixel_cfg[i][etseg_pkg::BP_VALID] &&
					bad_pixel_cfg[i][2*XW-1:XW] == col &&
					bad_pixel_cfg[i][XW-1:0] == row)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// queues a close marker when the open segment holds events
	function automatic int seal_segment();
		etseg_pkg::result_t marker;
		if (!seg_busy)
			return 0;
		marker = '{kind: etseg_pkg::RK_CLOSE, seg_start: seg_start_ns, time_ns: '0,
			col: '0, row: '0, pol: 1'b0, last: 1'b0};
		pending_results.insert(pending_results.size(), marker);
		seg_busy = 1'b0;
		return 1;
	endfunction

	function automatic void segment_predict(input camera_item_t it);
		etseg_pkg::result_t rec;
		logic [63:0] len;
		logic [63:0] elapsed;
		int n;
		n = 0;
		len = (seglen_cfg == '0) ? 64'd1 : 64'(seglen_cfg);
		if (stream_done)
			return;
		if (it.kind == etseg_pkg::REQ_FLUSH) begin
			n = seal_segment();
			stream_done = 1'b1;
		end else begin
			if (!base_fixed) begin
				base_fixed = 1'b1;
				win_open_ns = clamp_time_sum(it.ts, offset_cfg);
				win_close_ns = (window_cfg != '0) ? clamp_time_sum(win_open_ns, window_cfg) : '0;
			end
			if (it.ts < win_open_ns)
				return;
			if (window_cfg != '0 && it.ts >= win_close_ns) begin
				n = seal_segment();
				stream_done = 1'b1;
			end else begin
				if (!window_entered) begin
					window_entered = 1'b1;
					seg_start_ns = win_open_ns;
				end
				if (pixel_blocked(it.col, it.row))
					return;
				elapsed = (it.ts > seg_start_ns) ? 64'(it.ts - seg_start_ns) : 64'd0;
				if (elapsed >= len) begin
					n = seal_segment();
					seg_start_ns = seg_start_ns + TW'((elapsed / len) * len);
				end
				rec = '{kind: etseg_pkg::RK_RECORD, seg_start: seg_start_ns, time_ns: it.ts,
					col: it.col, row: it.row, pol: it.pol, last: 1'b0};
				pending_results.insert(pending_results.size(), rec);
				seg_busy = 1'b1;
				n++;
			end
		end
		if (n > 0)
			pending_results[pending_results.size()-1].last = 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [TW-1:0] want,
			input logic [TW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= etseg_pkg::REQ_EVENT;
			event_time_ns <= '0;
			pixel_col <= '0;
			pixel_row <= '0;
			polarity <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				segment_predict(item_on_port);
			if (!in_valid || !in_stall) begin
				if (event_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					item_on_port = event_queue.pop_front();
					in_valid <= 1'b1;
					req_type <= item_on_port.kind;
					event_time_ns <= item_on_port.ts;
					pixel_col <= item_on_port.col;
					pixel_row <= item_on_port.row;
					polarity <= item_on_port.pol;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		etseg_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer: kind %0d segment %0h", result_kind,
						segment_start_ns);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", want.kind, result_kind);
					check_field("segment_start_ns", want.seg_start, segment_start_ns);
					check_field("out_time_ns", want.time_ns, out_time_ns);
					check_field("out_col", want.col, out_col);
					check_field("out_row", want.row, out_row);
					check_field("out_polarity", want.pol, out_polarity);
					check_field("last_of_run", want.last, last_of_run);
				end
			end
			out_stall <= long_hold_on || ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			etseg_pkg::CFG_START_OFFSET: offset_cfg = value;
			etseg_pkg::CFG_WINDOW_LENGTH: window_cfg = value;
			etseg_pkg::CFG_SEGMENT_LENGTH: seglen_cfg = value;
			default: bad_pixel_cfg[SLOT_BITS'(idx - etseg_pkg::CFG_BAD_PIXEL_A)] =
				value[etseg_pkg::BP_BITS-1:0];
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_event(input logic [TW-1:0] ts, input logic [XW-1:0] col,
			input logic [XW-1:0] row, input logic pol);
		camera_item_t it;
		it = '{kind: etseg_pkg::REQ_EVENT, ts: ts, col: col, row: row, pol: pol};
		event_queue.insert(event_queue.size(), it);
	endtask

	task automatic push_flush();
		camera_item_t it;
		it = '{kind: etseg_pkg::REQ_FLUSH, ts: TW'(wide_rand()),
			col: XW'($urandom), row: XW'($urandom), pol: 1'($urandom)};
		event_queue.insert(event_queue.size(), it);
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic start_long_hold();
		fork
			begin
				long_hold_on = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_on = 1'b0;
			end
		join_none
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (event_queue.size() != 0 || in_valid || pending_results.size() != 0 ||
			long_hold_on);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_random_events(input int count);
		logic [63:0] len;
		logic [63:0] stride;
		logic [63:0] r;
		logic [TW-1:0] ts;
		logic [XW-1:0] col;
		logic [XW-1:0] row;
		int pick;
		int slot;
		len = (seglen_cfg == '0) ? 64'd1 : 64'(seglen_cfg);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			stride = 0;
			if (pick < 55)
				stride = wide_rand() % (len / 2 + 1);
			else if (pick < 70)
				stride = wide_rand() % (4 * len) + 1;
			else if (pick < 75)
				stride = wide_rand() % 64;
			if (stride < STRIDE_CAP && 64'(time_cursor) + stride <= 64'(CURSOR_CAP))
				time_cursor = time_cursor + TW'(stride);
			ts = time_cursor;
			col = XW'($urandom);
			row = XW'($urandom);
			if (pick >= 75 && pick < 85) begin
				slot = $urandom_range(0, SLOTS - 1);
				col = bad_pixel_cfg[slot][2*XW-1:XW];
				row = bad_pixel_cfg[slot][XW-1:0];
			end else if (pick >= 85 && pick < 90) begin
				ts = time_cursor - TW'(wide_rand() % (2 * len + 1));
			end else if (pick >= 90 && pick < 95) begin
				r = wide_rand();
				ts = {1'b0, r[TW-2:0]};
			end
			push_event(ts, col, row, 1'($urandom));
		end
	endtask

	task automatic run_phase(input flow_t mode, input logic [CW-1:0] offset,
			input logic [CW-1:0] winlen, input logic [CW-1:0] seglen,
			input int count, input bit long_hold);
		write_reg(etseg_pkg::CFG_START_OFFSET, offset);
		write_reg(etseg_pkg::CFG_WINDOW_LENGTH, winlen);
		write_reg(etseg_pkg::CFG_SEGMENT_LENGTH, seglen);
		for (int i = 0; i < SLOTS; i++)
			write_reg(IW'(etseg_pkg::CFG_BAD_PIXEL_A + i),
				CW'({($urandom_range(0, 3) != 0), XW'($urandom), XW'($urandom)}));
		@(negedge clk);
		case (mode)
			FLOW_FREE: begin send_gap_pct = 0; recv_stall_pct = 0; end
			FLOW_SEND_GAPS: begin send_gap_pct = 76; recv_stall_pct = 0; end
			FLOW_RECV_STALLS: begin send_gap_pct = 0; recv_stall_pct = 76; end
			default: begin send_gap_pct = 8; recv_stall_pct = 8; end
		endcase
		if (long_hold)
			start_long_hold();
		add_random_events(count);
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// window begin lands on WIN_OPEN, window end saturates
		write_reg(etseg_pkg::CFG_START_OFFSET, CFG_MAX);
		write_reg(etseg_pkg::CFG_WINDOW_LENGTH, CFG_MAX);
		write_reg(etseg_pkg::CFG_SEGMENT_LENGTH, 48'd1000);
		write_reg(etseg_pkg::CFG_BAD_PIXEL_A, CW'({1'b1, 11'd2047, 11'd0}));
		write_reg(IW'(etseg_pkg::CFG_BAD_PIXEL_A + 1), CW'({1'b1, 11'd0, 11'd2047}));
		write_reg(IW'(etseg_pkg::CFG_BAD_PIXEL_A + 2), CW'({1'b0, 11'd5, 11'd5}));
		write_reg(IW'(etseg_pkg::CFG_BAD_PIXEL_A + 3), CW'({1'b1, 11'd2047, 11'd2047}));
		@(negedge clk);
		push_event(WIN_OPEN - TW'(CFG_MAX), 11'd0, 11'd0, 1'b0);
		push_event('0, 11'd0, 11'd0, 1'b1);
		push_event(WIN_OPEN - 1, 11'd3, 11'd4, 1'b1);
		push_event(WIN_OPEN, 11'd2047, 11'd0, 1'b1);
		push_event(WIN_OPEN, 11'd0, 11'd0, 1'b1);
		push_event(WIN_OPEN + 999, 11'd2047, 11'd2047, 1'b0);
		push_event(WIN_OPEN + 999, 11'd5, 11'd5, 1'b0);
		push_event(WIN_OPEN + 1000, 11'd1234, 11'd777, 1'b1);
		push_event(WIN_OPEN + 5500, 11'd1, 11'd2, 1'b0);
		push_event(WIN_OPEN + 100, 11'd2, 11'd1, 1'b1);
		push_event(WIN_OPEN + 9000, 11'd0, 11'd2047, 1'b1);
		push_event(WIN_OPEN + 20000, 11'd1, 11'd1, 1'b0);
		push_event(WIN_OPEN + 20000, 11'd2046, 11'd2047, 1'b1);
		time_cursor = WIN_OPEN + 20000;
		settle();

		run_phase(FLOW_FREE, '0, CFG_MAX, CW'($urandom_range(1, 5000)), 160, 1'b0);
		run_phase(FLOW_SEND_GAPS, CW'(wide_rand()), CFG_MAX, '0, 110, 1'b0);
		run_phase(FLOW_RECV_STALLS, CW'(wide_rand()), '0,
			CW'($urandom_range(1, 1 << 20)), 150, 1'b1);
		run_phase(FLOW_BOTH, CW'(wide_rand()), CW'(wide_rand()) | 1,
			CW'($urandom), 150, 1'b0);
		run_phase(FLOW_FREE, CFG_MAX, CFG_MAX, CFG_MAX, 50, 1'b0);
		run_phase(FLOW_RECV_STALLS, CW'(wide_rand()), CFG_MAX, 48'd1, 140, 1'b1);
		run_phase(FLOW_SEND_GAPS, CW'(wide_rand()), '0,
			CW'($urandom_range(1, 1 << 30)), 130, 1'b0);

		// no end limit: the top of the time range is kept
		write_reg(etseg_pkg::CFG_WINDOW_LENGTH, '0);
		@(negedge clk);
		push_event(TIME_MAX, 11'd1, 11'd2, 1'b1);
		push_event(time_cursor, 11'd3, 11'd2, 1'b0);
		push_event(TIME_MAX, 11'd2047, 11'd1, 1'b1);
		settle();

		// stream end, then items that must be ignored
		write_reg(etseg_pkg::CFG_WINDOW_LENGTH, CFG_MAX);
		@(negedge clk);
		if ($urandom_range(0, 1))
			push_flush();
		else
			push_event(TIME_MAX, 11'd4, 11'd4, 1'b0);
		push_flush();
		push_event(TIME_MAX, 11'd7, 11'd9, 1'b1);
		push_event(time_cursor, 11'd9, 11'd7, 1'b0);
		settle();

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS event_time_segmenter_top");
		else
			$display("FAIL event_time_segmenter_top");
		$finish;
	end

endmodule
